// ===== src/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and entity tables for the HTML entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_LT   = 8'h3C;
   localparam logic [7:0] CHAR_GT   = 8'h3E;
   localparam logic [7:0] CHAR_QUOT = 8'h22;
   localparam logic [7:0] CHAR_L    = 8'h6C;
   localparam logic [7:0] CHAR_G    = 8'h67;
   localparam logic [7:0] CHAR_Q    = 8'h71;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_T    = 8'h74;
   localparam logic [7:0] CHAR_U    = 8'h75;
   localparam logic [7:0] CHAR_O    = 8'h6F;
   localparam logic [7:0] CHAR_M    = 8'h6D;
   localparam logic [7:0] CHAR_P    = 8'h70;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   localparam logic [2:0] PREFIX_MAX = 3'd5;

   typedef enum logic [1:0] {
      ENT_LT   = 2'd0,
      ENT_GT   = 2'd1,
      ENT_QUOT = 2'd2,
      ENT_AMP  = 2'd3
   } ent_type;

   // one decoded request: a_len literal entity bytes, then an optional extra byte
   typedef struct packed {
      logic       has_out;
      ent_type    sel;
      logic [2:0] a_len;
      logic       e_valid;
      logic [7:0] e_char;
      logic       last;
   } job_type;

   function automatic logic [7:0] ent_text(input ent_type sel, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (idx == 3'd0) begin
         ch = CHAR_AMP;
      end else begin
         unique case (sel)
            ENT_LT: begin
               case (idx)
                  3'd1: ch = CHAR_L;
                  3'd2: ch = CHAR_T;
                  3'd3: ch = CHAR_SEMI;
                  default: ch = 8'h00;
               endcase
            end
            ENT_GT: begin
               case (idx)
                  3'd1: ch = CHAR_G;
                  3'd2: ch = CHAR_T;
                  3'd3: ch = CHAR_SEMI;
                  default: ch = 8'h00;
               endcase
            end
            ENT_QUOT: begin
               case (idx)
                  3'd1: ch = CHAR_Q;
                  3'd2: ch = CHAR_U;
                  3'd3: ch = CHAR_O;
                  3'd4: ch = CHAR_T;
                  3'd5: ch = CHAR_SEMI;
                  default: ch = 8'h00;
               endcase
            end
            ENT_AMP: begin
               case (idx)
                  3'd1: ch = CHAR_A;
                  3'd2: ch = CHAR_M;
                  3'd3: ch = CHAR_P;
                  3'd4: ch = CHAR_SEMI;
                  default: ch = 8'h00;
               endcase
            end
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   function automatic logic [2:0] ent_len(input ent_type sel);
      logic [2:0] len;
      unique case (sel)
         ENT_LT:   len = 3'd4;
         ENT_GT:   len = 3'd4;
         ENT_QUOT: len = 3'd6;
         ENT_AMP:  len = 3'd5;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] ent_char(input ent_type sel);
      logic [7:0] ch;
      unique case (sel)
         ENT_LT:   ch = CHAR_LT;
         ENT_GT:   ch = CHAR_GT;
         ENT_QUOT: ch = CHAR_QUOT;
         ENT_AMP:  ch = CHAR_AMP;
         default:  ch = CHAR_LT;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/hed_ifs.sv =====
// ----------------------------------------------------------------------------
// hed_ifs
// Request and response channel interfaces of the HTML entity decoder.
// ----------------------------------------------------------------------------
interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_end;
   logic       string_end;

   modport source (output valid, output out_char, output run_end, output string_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_end, input string_end,
                   output ready);
endinterface

// ===== src/hed_decode.sv =====
// ----------------------------------------------------------------------------
// hed_decode
// Entity prefix matcher: holds the match state and turns each request byte
// into a job of literal entity bytes plus an optional extra byte.
// ----------------------------------------------------------------------------
module hed_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  logic [7:0]       req_char,
   input  logic             req_last,
   output hed_pkg::job_type job_out
);

   logic [2:0]       prefix_len_ff, prefix_len_in;
   hed_pkg::ent_type entity_sel_ff, entity_sel_in;

   always_comb begin
      logic             idle;
      logic             brk;
      hed_pkg::job_type job;
      logic [2:0]       np;
      hed_pkg::ent_type ns;

      idle = (prefix_len_ff == 3'd0) || (prefix_len_ff > hed_pkg::PREFIX_MAX);
      brk  = 1'b0;
      np   = prefix_len_ff;
      ns   = entity_sel_ff;
      job.has_out = 1'b0;
      job.sel     = entity_sel_ff;
      job.a_len   = 3'd0;
      job.e_valid = 1'b0;
      job.e_char  = req_char;
      job.last    = req_last;

      if (idle) begin
         ns = hed_pkg::ENT_LT;
         if (req_char == hed_pkg::CHAR_AMP) begin
            np = 3'd1;
         end else begin
            np = 3'd0;
            job.e_valid = 1'b1;
         end
      end else if (prefix_len_ff == 3'd1) begin
         np = 3'd2;
         case (req_char)
            hed_pkg::CHAR_L: ns = hed_pkg::ENT_LT;
            hed_pkg::CHAR_G: ns = hed_pkg::ENT_GT;
            hed_pkg::CHAR_Q: ns = hed_pkg::ENT_QUOT;
            hed_pkg::CHAR_A: ns = hed_pkg::ENT_AMP;
            default:         brk = 1'b1;
         endcase
      end else if (req_char == hed_pkg::ent_text(entity_sel_ff, prefix_len_ff)) begin
         if (prefix_len_ff + 3'd1 == hed_pkg::ent_len(entity_sel_ff)) begin
            job.e_valid = 1'b1;
            job.e_char  = hed_pkg::ent_char(entity_sel_ff);
            np = 3'd0;
            ns = hed_pkg::ENT_LT;
         end else begin
            np = prefix_len_ff + 3'd1;
         end
      end else begin
         brk = 1'b1;
      end

      if (brk) begin
         job.a_len = prefix_len_ff;
         ns = hed_pkg::ENT_LT;
         if (req_char == hed_pkg::CHAR_AMP) begin
            np = 3'd1;
         end else begin
            np = 3'd0;
            job.e_valid = 1'b1;
         end
      end

      // end of string: flush the open prefix
      if (req_last && np != 3'd0) begin
         if (job.a_len == 3'd0) begin
            job.a_len = np;
            job.sel   = ns;
         end else begin
            job.e_valid = 1'b1;
            job.e_char  = hed_pkg::CHAR_AMP;
         end
         np = 3'd0;
         ns = hed_pkg::ENT_LT;
      end

      job.has_out   = (job.a_len != 3'd0) || job.e_valid;
      job_out       = job;
      prefix_len_in = req_accept ? np : prefix_len_ff;
      entity_sel_in = req_accept ? ns : entity_sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff <= 3'd0;
         entity_sel_ff <= hed_pkg::ENT_LT;
      end else begin
         prefix_len_ff <= prefix_len_in;
         entity_sel_ff <= entity_sel_in;
      end
   end

`ifndef ASSERT_OFF
   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      prefix_len_ff <= hed_pkg::PREFIX_MAX)
      else $error("prefix length out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last) |=> prefix_len_ff == 3'd0)
      else $error("match state open after end of string");
`endif

endmodule

// ===== src/hed_emit.sv =====
// ----------------------------------------------------------------------------
// hed_emit
// Job register and response register: walks a job one byte per cycle while the
// response register is free, and marks run and string ends.
// ----------------------------------------------------------------------------
module hed_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_load,
   input  hed_pkg::job_type job_new,
   output logic             take_ready,
   hed_rsp_if.source        rsp_bus
);

   hed_pkg::job_type job_ff, job_in;
   logic             busy_ff, busy_in;
   logic [2:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             run_end_ff, run_end_in;
   logic             string_end_ff, string_end_in;

   logic             out_load;
   logic             is_final;
   logic             job_done;
   logic [7:0]       cur_char;

   always_comb begin
      cur_char = (idx_ff < job_ff.a_len) ? hed_pkg::ent_text(job_ff.sel, idx_ff)
                                         : job_ff.e_char;
      is_final = job_ff.e_valid ? (idx_ff == job_ff.a_len)
                                : (idx_ff == job_ff.a_len - 3'd1);
      out_load   = busy_ff && (!rsp_valid_ff || rsp_bus.ready);
      job_done   = out_load && is_final;
      take_ready = !busy_ff || job_done;

      job_in  = job_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (job_load && job_new.has_out) begin
         job_in  = job_new;
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (job_done) begin
         busy_in = 1'b0;
      end else if (out_load) begin
         idx_in = idx_ff + 3'd1;
      end

      rsp_valid_in  = rsp_valid_ff;
      out_char_in   = out_char_ff;
      run_end_in    = run_end_ff;
      string_end_in = string_end_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         out_char_in   = cur_char;
         run_end_in    = is_final;
         string_end_in = is_final && job_ff.last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      out_char_ff   <= out_char_in;
      run_end_ff    <= run_end_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_char   = out_char_ff;
   assign rsp_bus.run_end    = run_end_ff;
   assign rsp_bus.string_end = string_end_ff;

`ifndef ASSERT_OFF
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= job_ff.a_len)
      else $error("job index past end of job");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      (job_load && job_new.has_out) |=> busy_ff && idx_ff == 3'd0)
      else $error("job not taken");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (job_done && !job_load) |=> !busy_ff)
      else $error("job still busy after its final byte");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !out_load) |=> busy_ff && $stable(idx_ff))
      else $error("job advanced without a response slot");
`endif

endmodule

// ===== src/html_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming decoder for the entities &lt; &gt; &quot; &amp;.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one byte of the encoded string per request, with in_last
//   on the final byte. rsp_bus returns decoded bytes; run_end marks the last
//   byte caused by one request, string_end the final byte of the string.
//   A request that only extends an entity match produces no response.
// Path: an accepted request is decoded into the job register; its first byte
//   then passes to the response register, which drives rsp_bus.
// Throughput: one request per cycle while no request yields over one byte
//   and rsp_bus.ready stays high. A request yielding more bytes (a broken or
//   flushed prefix, up to six) holds req_bus.ready low while its job is walked.
// Reset: clears the match state, the job busy flag and the response valid.
// Stall: when rsp_bus.ready is low a valid response register holds; a pending job
//   keeps its bytes and req_bus.ready stays low until the response register
//   frees up. With no job pending, one request is still accepted.
// ----------------------------------------------------------------------------
module html_entity_decoder (
   input  logic      clock,
   input  logic      reset,
   hed_req_if.sink   req_bus,
   hed_rsp_if.source rsp_bus
);

   logic             req_accept;
   logic             take_ready;
   hed_pkg::job_type job;

   assign req_bus.ready = take_ready;
   assign req_accept    = req_bus.valid && take_ready;

   hed_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_char   (req_bus.in_char),
      .req_last   (req_bus.in_last),
      .job_out    (job)
   );

   hed_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_load   (req_accept),
      .job_new    (job),
      .take_ready (take_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule
